// ----- design/pmc_pkg.sv -----
// Shared types, codes and defaults for the Prim maze carver.
package pmc_pkg;

  // default grid size
  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 64;

  // width of the random fields
  localparam int RAND_W = 15;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // cell codes
  localparam logic [1:0] CELL_ROAD = 2'd0;
  localparam logic [1:0] CELL_WALL = 2'd1;
  localparam logic [1:0] CELL_WAIT = 2'd2;

  // neighbor directions, checked in this order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic               command;
    logic [RAND_W-1:0]  frontier_random;
    logic [RAND_W-1:0]  link_random;
  } cmd_word_t;

  typedef struct packed {
    logic [6:0]  cell_x;
    logic [5:0]  cell_y;
    logic [6:0]  passage_x;
    logic [5:0]  passage_y;
    logic        passage_valid;
    logic        finished;
    logic [11:0] frontier_size;
  } res_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_MODF,
    S_ENT_RD,
    S_ENT_WAIT,
    S_NB_RD,
    S_NB_CHK,
    S_MODL,
    S_CARVE,
    S_ROAD,
    S_ADD_RD,
    S_ADD_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

// ----- design/pmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pmc_ram import pmc_pkg::*; #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pmc_mod.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
module pmc_mod import pmc_pkg::*; #(
  parameter int DIV_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  rem
);

  localparam int CNT_W = $clog2(RAND_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] dvd;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;

  assign trial = {rem, dvd[RAND_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= DIV_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/random_prim_maze_carver.sv -----
// Randomized Prim maze carver: sequencer, cell map, frontier list, output word.
// Start word: sweeps the whole map to wall, then seeds the corner cell and appends its walls.
// Step word: the entry-pick remainder, the neighbor reads, the link remainder, the wall
//   appends and the remaining states, then a read and a write for each frontier entry above
//   the picked one (single read port of the list).
// One word in flight at a time; a new word is taken once the result is loaded.
// Synchronous reset clears the sequencer, the frontier count and the result valid flag.
module random_prim_maze_carver import pmc_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  localparam int XW  = $clog2(GRID_WIDTH);
  localparam int YW  = $clog2(GRID_HEIGHT);
  localparam int AW  = XW + YW;
  localparam int FD  = ((GRID_WIDTH + 1) / 2) * ((GRID_HEIGHT + 1) / 2);
  localparam int FAW = $clog2(FD);
  localparam int CW  = $clog2(FD + 1);

  state_t state, state_next;

  logic              is_start;
  logic [RAND_W-1:0] lr;
  logic [FAW-1:0]    idx;
  logic [FAW-1:0]    sp;
  logic [XW-1:0]     ax;
  logic [YW-1:0]     ay;
  logic [1:0]        dir;
  logic [3:0]        cand;
  logic [XW-1:0]     px;
  logic [YW-1:0]     py;
  logic              pv;
  logic              fin;
  logic [CW-1:0]     count;
  logic [AW-1:0]     sweep;

  logic accept;
  assign accept = cmd_valid && !cmd_stall;

  // map and frontier memories
  logic            m_we;
  logic [AW-1:0]   m_waddr, m_raddr;
  logic [1:0]      m_wdata, m_rdata;
  logic            f_we;
  logic [FAW-1:0]  f_waddr, f_raddr;
  logic [AW-1:0]   f_wdata, f_rdata;

  pmc_ram #(.WIDTH(2), .DEPTH(2 ** AW)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  pmc_ram #(.WIDTH(AW), .DEPTH(2 ** FAW)) u_list (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // shared remainder unit
  logic              mod_start, mod_done;
  logic [RAND_W-1:0] mod_dvd;
  logic [CW-1:0]     mod_dvs, mod_rem;

  pmc_mod #(.DIV_W(CW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(mod_dvd),
    .divisor(mod_dvs), .done(mod_done), .rem(mod_rem)
  );

  // neighbors at distance two and their range checks
  logic [XW:0]   xe;
  logic [YW:0]   ye;
  logic [3:0]    nb_ok_vec;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] pass_addr;

  assign xe = {1'b0, ax};
  assign ye = {1'b0, ay};
  assign nb_ok_vec[DIR_UP]    = ye >= (YW+1)'(2);
  assign nb_ok_vec[DIR_DOWN]  = ye + (YW+1)'(2) <= (YW+1)'(GRID_HEIGHT - 1);
  assign nb_ok_vec[DIR_LEFT]  = xe >= (XW+1)'(2);
  assign nb_ok_vec[DIR_RIGHT] = xe + (XW+1)'(2) <= (XW+1)'(GRID_WIDTH - 1);
  assign nb_ok     = nb_ok_vec[dir];
  assign cell_addr = {ay, ax};
  assign pass_addr = {py, px};

  always_comb begin
    case (dir)
      DIR_UP:    nb_addr = {ay - YW'(2), ax};
      DIR_DOWN:  nb_addr = {ay + YW'(2), ax};
      DIR_LEFT:  nb_addr = {ay, ax - XW'(2)};
      DIR_RIGHT: nb_addr = {ay, ax + XW'(2)};
      default:   nb_addr = cell_addr;
    endcase
  end

  // road neighbors seen so far, including the one checked now
  logic [3:0] cand_next;
  logic [2:0] cand_cnt;
  always_comb begin
    cand_next = cand;
    if (state == S_NB_CHK && nb_ok && m_rdata == CELL_ROAD) begin
      cand_next[dir] = 1'b1;
    end
    cand_cnt = 3'(cand_next[0]) + 3'(cand_next[1]) + 3'(cand_next[2]) + 3'(cand_next[3]);
  end

  // k-th road neighbor, k from the link remainder
  logic [1:0] pick;
  logic [2:0] seen;
  always_comb begin
    pick = DIR_UP;
    seen = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, mod_rem[1:0]}) begin
          pick = 2'(i);
        end
        seen = seen + 3'd1;
      end
    end
  end

  logic [CW-1:0] sp_plus;
  assign sp_plus = CW'(sp) + CW'(1);

  logic add_hit;
  assign add_hit = nb_ok && m_rdata == CELL_WALL && count < CW'(FD);

  logic load_res;
  assign load_res = state == S_DONE && (!res_valid || !res_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.command == CMD_START) begin
            state_next = S_CLEAR;
          end else if (count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MODF;
          end
        end
      end
      S_CLEAR:    if (sweep == '1) state_next = S_SEED;
      S_SEED:     state_next = S_ADD_RD;
      S_MODF:     if (mod_done) state_next = S_ENT_RD;
      S_ENT_RD:   state_next = S_ENT_WAIT;
      S_ENT_WAIT: state_next = S_NB_RD;
      S_NB_RD:    state_next = S_NB_CHK;
      S_NB_CHK: begin
        if (dir != DIR_RIGHT) begin
          state_next = S_NB_RD;
        end else if (cand_cnt != '0) begin
          state_next = S_MODL;
        end else begin
          state_next = S_ROAD;
        end
      end
      S_MODL:     if (mod_done) state_next = S_CARVE;
      S_CARVE:    state_next = S_ROAD;
      S_ROAD:     state_next = S_ADD_RD;
      S_ADD_RD:   state_next = S_ADD_CHK;
      S_ADD_CHK: begin
        if (dir != DIR_RIGHT) begin
          state_next = S_ADD_RD;
        end else if (is_start) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_next = (sp_plus < count) ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE:     if (load_res) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    cmd_stall = state != S_IDLE;
    m_we      = 1'b0;
    m_waddr   = cell_addr;
    m_wdata   = CELL_ROAD;
    m_raddr   = nb_addr;
    f_we      = 1'b0;
    f_waddr   = count[FAW-1:0];
    f_wdata   = nb_addr;
    f_raddr   = idx;
    mod_start = 1'b0;
    mod_dvd   = lr;
    mod_dvs   = CW'(cand_cnt);
    case (state)
      S_IDLE: begin
        mod_dvd   = cmd.frontier_random;
        mod_dvs   = count;
        mod_start = accept && cmd.command == CMD_STEP && count != '0;
      end
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = sweep;
        m_wdata = CELL_WALL;
      end
      S_SEED: begin
        m_we    = 1'b1;
        m_waddr = '0;
      end
      S_NB_CHK:   mod_start = dir == DIR_RIGHT && cand_cnt != '0;
      S_CARVE: begin
        m_we    = 1'b1;
        m_waddr = pass_addr;
      end
      S_ROAD:     m_we = 1'b1;
      S_ADD_CHK: begin
        m_we    = add_hit;
        m_waddr = nb_addr;
        m_wdata = CELL_WAIT;
        f_we    = add_hit;
      end
      S_SHIFT_RD: f_raddr = sp_plus[FAW-1:0];
      S_SHIFT_WR: begin
        f_we    = 1'b1;
        f_waddr = sp;
        f_wdata = f_rdata;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_start <= cmd.command == CMD_START;
            lr       <= cmd.link_random;
            ax       <= '0;
            ay       <= '0;
            px       <= '0;
            py       <= '0;
            pv       <= 1'b0;
            fin      <= cmd.command == CMD_STEP && count == '0;
            sweep    <= '0;
            dir      <= DIR_UP;
            cand     <= '0;
          end
        end
        S_CLEAR: sweep <= sweep + AW'(1);
        S_SEED:  count <= '0;
        S_MODF: begin
          if (mod_done) begin
            idx <= mod_rem[FAW-1:0];
          end
        end
        S_ENT_WAIT: begin
          ax <= f_rdata[XW-1:0];
          ay <= f_rdata[AW-1:XW];
        end
        S_NB_CHK: begin
          cand <= cand_next;
          dir  <= dir + 2'd1;
        end
        S_CARVE: begin
          pv <= 1'b1;
        end
        S_ROAD: sp <= idx;
        S_ADD_CHK: begin
          dir <= dir + 2'd1;
          if (add_hit) begin
            count <= count + CW'(1);
          end
        end
        S_SHIFT_RD: begin
          if (!(sp_plus < count)) begin
            count <= count - CW'(1);
          end
        end
        S_SHIFT_WR: sp <= sp_plus[FAW-1:0];
        default: ;
      endcase
      // passage coordinates follow the picked direction
      if (state == S_MODL && mod_done) begin
        case (pick)
          DIR_UP:    begin px <= ax;            py <= ay - YW'(1); end
          DIR_DOWN:  begin px <= ax;            py <= ay + YW'(1); end
          DIR_LEFT:  begin px <= ax - XW'(1);   py <= ay;          end
          DIR_RIGHT: begin px <= ax + XW'(1);   py <= ay;          end
          default:   begin px <= ax;            py <= ay;          end
        endcase
      end
    end
  end

  // result word
  logic [15:0] ax16, ay16, px16, py16, cnt16;
  assign ax16  = 16'(ax);
  assign ay16  = 16'(ay);
  assign px16  = 16'(px);
  assign py16  = 16'(py);
  assign cnt16 = 16'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.cell_x        <= ax16[6:0];
      res.cell_y        <= ay16[5:0];
      res.passage_x     <= px16[6:0];
      res.passage_y     <= py16[5:0];
      res.passage_valid <= pv;
      res.finished      <= fin;
      res.frontier_size <= cnt16[11:0];
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FD))
    else $error("frontier count above list depth");

  a_empty_step: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == CMD_STEP && count == '0 |=> state == S_DONE && fin)
    else $error("step on empty frontier did not finish at once");

  a_fin_no_pass: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.finished |-> !res.passage_valid)
    else $error("finished word reports a passage");

  a_mod_only_busy: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MODF || state == S_MODL)
    else $error("remainder finished outside a wait state");

endmodule

// ----- bench/testbench.sv -----
// Testbench for the Prim maze carver: random command words checked against a predictor.
`timescale 1ns / 1ps

module testbench import pmc_pkg::*;;

  localparam int GW = GRID_WIDTH_DEF;
  localparam int GH = GRID_HEIGHT_DEF;
  localparam int CELLS = GW * GH;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res;

  int     errors = 0;
  longint cycles = 0;
  bit     quiet = 1'b0;  // no idling on either side while set

  random_prim_maze_carver u_top (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Predicts carver results and holds the ones still owed by the block
  class maze_scoreboard;
    logic [1:0] grid[CELLS];
    int         frontier[$];
    res_word_t  owed[$];

    function new();
      foreach (grid[i]) grid[i] = CELL_WALL;
    endfunction

    function void push_wall(int x, int y);
      int c;
      c = y * GW + x;
      if (grid[c] != CELL_WALL || frontier.size() >= (GW / 2) * (GH / 2)) return;
      frontier.insert(frontier.size(), c);
      grid[c] = CELL_WAIT;
    endfunction

    function void grow(int x, int y);
      if (y >= 2) push_wall(x, y - 2);
      if (y + 2 <= GH - 1) push_wall(x, y + 2);
      if (x >= 2) push_wall(x - 2, y);
      if (x + 2 <= GW - 1) push_wall(x + 2, y);
    endfunction

    function bit is_road(int x, int y);
      return grid[y * GW + x] == CELL_ROAD;
    endfunction

    // take one accepted command word and work out its result
    function void note(cmd_word_t w);
      res_word_t r;
      int idx, e, ax, ay, n, k;
      int cx[4], cy[4];
      r = '0;
      if (w.command == CMD_START) begin
        foreach (grid[i]) grid[i] = CELL_WALL;
        frontier.delete();
        grid[0] = CELL_ROAD;
        grow(0, 0);
      end else if (frontier.size() == 0) begin
        r.finished = 1'b1;
      end else begin
        idx = int'(w.frontier_random) % frontier.size();
        e = frontier[idx];
        ax = e % GW;
        ay = e / GW;
        n = 0;
        if (ay >= 2 && is_road(ax, ay - 2)) begin cx[n] = ax; cy[n] = ay - 1; n++; end
        if (ay + 2 <= GH - 1 && is_road(ax, ay + 2)) begin
          cx[n] = ax; cy[n] = ay + 1; n++;
        end
        if (ax >= 2 && is_road(ax - 2, ay)) begin cx[n] = ax - 1; cy[n] = ay; n++; end
        if (ax + 2 <= GW - 1 && is_road(ax + 2, ay)) begin
          cx[n] = ax + 1; cy[n] = ay; n++;
        end
        if (n > 0) begin
          k = int'(w.link_random) % n;
          r.passage_x = 7'(cx[k]);
          r.passage_y = 6'(cy[k]);
          r.passage_valid = 1'b1;
          grid[cy[k] * GW + cx[k]] = CELL_ROAD;
        end
        grid[e] = CELL_ROAD;
        grow(ax, ay);
        frontier.delete(idx);
        r.cell_x = 7'(ax);
        r.cell_y = 6'(ay);
      end
      r.frontier_size = 12'(frontier.size());
      owed.insert(owed.size(), r);
    endfunction

    // compare one accepted result word with the oldest owed one
    task check(res_word_t g);
      res_word_t x;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result word %h", g));
        return;
      end
      x = owed.pop_front();
      if (g.cell_x != x.cell_x) report($sformatf("cell_x %0d, want %0d", g.cell_x, x.cell_x));
      if (g.cell_y != x.cell_y) report($sformatf("cell_y %0d, want %0d", g.cell_y, x.cell_y));
      if (g.passage_x != x.passage_x)
        report($sformatf("passage_x %0d, want %0d", g.passage_x, x.passage_x));
      if (g.passage_y != x.passage_y)
        report($sformatf("passage_y %0d, want %0d", g.passage_y, x.passage_y));
      if (g.passage_valid != x.passage_valid)
        report($sformatf("passage_valid %0d, want %0d", g.passage_valid, x.passage_valid));
      if (g.finished != x.finished)
        report($sformatf("finished %0d, want %0d", g.finished, x.finished));
      if (g.frontier_size != x.frontier_size)
        report($sformatf("frontier_size %0d, want %0d", g.frontier_size, x.frontier_size));
    endtask
  endclass

  maze_scoreboard sb = new();

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // result side: random stall, check every accepted word
  int stall_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (res_valid && !res_stall) sb.check(res);
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        res_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("random_prim_maze_carver: mismatch");
      $finish;
    end
  end

  // drive one command word and wait for it to be taken
  task automatic send(logic c, int fr, int lr);
    int gap;
    cmd_word_t w;
    w.command = c;
    w.frontier_random = RAND_W'(fr);
    w.link_random = RAND_W'(lr);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    sb.note(w);
  endtask

  task automatic step_rand();
    send(CMD_STEP, $urandom_range(0, 32767), $urandom_range(0, 32767));
  endtask

  initial begin
    int total, run;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: steps with an empty frontier, then field extremes
    send(CMD_STEP, 0, 0);
    send(CMD_STEP, 32767, 32767);
    send(CMD_START, 32767, 32767);
    send(CMD_STEP, 0, 0);
    send(CMD_STEP, 32767, 32767);
    send(CMD_STEP, 0, 32767);
    send(CMD_STEP, 32767, 0);
    repeat (8) step_rand();
    send(CMD_START, 0, 0);  // restart in the middle of a maze
    send(CMD_STEP, 1, 1);
    send(CMD_STEP, 2, 2);

    // random: restarts with runs of steps, some stretches with no idling
    total = 0;
    while (total < 562) begin
      quiet = ($urandom_range(0, 3) == 0);
      send(CMD_START, $urandom_range(0, 32767), $urandom_range(0, 32767));
      run = $urandom_range(60, 180);
      if (run > 561 - total) run = 561 - total;
      repeat (run) step_rand();
      total += run + 1;
    end
    quiet = 1'b0;
    @(posedge clk);
    cmd_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("random_prim_maze_carver: match");
    else
      $display("random_prim_maze_carver: mismatch");
    $finish;
  end

endmodule
